FILE: sv/tms_pkg.sv
// ----------------------------------------------------------------------------
// tms_pkg: shared types and codes of the Turing machine stepper
// Request kinds, result status codes, head moves, register map and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package tms_pkg;

  typedef enum logic [1:0] {
    FUNC_RULE    = 2'd0,
    FUNC_APPEND  = 2'd1,
    FUNC_RESTART = 2'd2,
    FUNC_STEP    = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    STAT_DONE     = 3'd0,
    STAT_STEPPED  = 3'd1,
    STAT_ACCEPTED = 3'd2,
    STAT_NO_RULE  = 3'd3,
    STAT_OFF_TAPE = 3'd4,
    STAT_FULL     = 3'd5
  } status_t;

  localparam logic [1:0] MOVE_LEFT  = 2'd0;
  localparam logic [1:0] MOVE_RIGHT = 2'd1;

  localparam logic [1:0] REG_START_STATE  = 2'd0;
  localparam logic [1:0] REG_ACCEPT_STATE = 2'd1;
  localparam logic [1:0] REG_BLANK_SYMBOL = 2'd2;

  localparam int RULE_W = 8;

  typedef enum logic {
    CTRL_IDLE = 1'b0,
    CTRL_EXEC = 1'b1
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic execute;
  } tms_cmd_t;

  typedef struct packed {
    logic out_free;
  } tms_stat_t;

endpackage

FILE: sv/turing_machine_stepper.sv
// ----------------------------------------------------------------------------
// turing_machine_stepper: single-tape Turing machine, one request at a time
// Requests arrive on the s_ stream: s_tuser selects the kind (write rule,
// append tape symbol, restart, one step) and s_tdata carries the rule and
// symbol fields. Every request yields exactly one result on the m_ stream
// with the status, the machine state, the head cell and the symbol seen.
// A request is taken in the idle state and carried out once the result
// register is free, where the tape cell under the head and the rule lanes of
// the current state, read together from their RAMs, are combined; the result
// is registered there. No new request is taken while one waits to be carried
// out. While a result waits in the output register the next request is still
// taken, and it is carried out once the receiver has taken the pending result;
// a stalled receiver thus holds the block after one request. Reset clears all
// rules, the tape marks and the halt flag, sets the head and load position to
// the middle cell and loads the configuration defaults. The APB port writes
// start state, accept state and blank symbol at addresses 0, 4 and 8; the user
// must write it only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module turing_machine_stepper #(
  parameter int TAPE_CELLS   = 64,
  parameter int STATE_COUNT  = 16,
  parameter int SYMBOL_COUNT = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // rule_state[3:0], rule_symbol[5:4], rule_next_state[9:6],
  // rule_write_symbol[11:10], rule_move[13:12], tape_symbol[15:14]
  input  logic [15:0] s_tdata,
  // func[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // status[2:0], machine_state[6:3], head_position[12:7], symbol_seen[14:13]
  output logic [15:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  tms_pkg::tms_cmd_t  cmd;
  tms_pkg::tms_stat_t stat;

  assign pready = 1'b1;

  tms_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  tms_datapath #(
    .TAPE_CELLS  (TAPE_CELLS),
    .STATE_COUNT (STATE_COUNT),
    .SYMBOL_COUNT(SYMBOL_COUNT)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .stat    (stat),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata)
  );

endmodule

FILE: sv/tms_ram.sv
// ----------------------------------------------------------------------------
// tms_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/tms_ctrl.sv
// ----------------------------------------------------------------------------
// tms_ctrl: request sequencer of the Turing machine stepper
// Takes a request in the idle state, then has the datapath carry it out as
// soon as the result register is free.
// ----------------------------------------------------------------------------
module tms_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  tms_pkg::tms_stat_t  stat,
  output tms_pkg::tms_cmd_t   cmd
);

  tms_pkg::ctrl_state_t state;
  tms_pkg::ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tms_pkg::CTRL_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      tms_pkg::CTRL_IDLE: begin
        if (s_tvalid) begin
          state_next = tms_pkg::CTRL_EXEC;
        end
      end
      tms_pkg::CTRL_EXEC: begin
        if (stat.out_free) begin
          state_next = tms_pkg::CTRL_IDLE;
        end
      end
      default: begin
        state_next = tms_pkg::CTRL_IDLE;
      end
    endcase
  end

  always_comb begin
    s_tready    = 1'b0;
    cmd.accept  = 1'b0;
    cmd.execute = 1'b0;
    case (state)
      tms_pkg::CTRL_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
      end
      tms_pkg::CTRL_EXEC: begin
        cmd.execute = stat.out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

endmodule

FILE: sv/tms_datapath.sv
// ----------------------------------------------------------------------------
// tms_datapath: tape, rule table, machine registers and result register
// Holds the configuration registers, the tape RAM with its written marks,
// one rule RAM lane per symbol with valid bits, and the output register.
// ----------------------------------------------------------------------------
module tms_datapath #(
  parameter int TAPE_CELLS   = 64,
  parameter int STATE_COUNT  = 16,
  parameter int SYMBOL_COUNT = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  tms_pkg::tms_cmd_t  cmd,
  output tms_pkg::tms_stat_t stat,
  input  logic [15:0]        s_tdata,
  input  logic [1:0]         s_tuser,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [15:0]        m_tdata,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata
);

  localparam int HW     = $clog2(TAPE_CELLS);
  localparam int LW     = $clog2(TAPE_CELLS + 1);
  localparam int ST_IW  = $clog2(STATE_COUNT);
  localparam int SYM_IW = $clog2(SYMBOL_COUNT);

  localparam logic [HW-1:0]       HEAD_MID   = HW'(TAPE_CELLS / 2);
  localparam logic [HW-1:0]       HEAD_LAST  = HW'(TAPE_CELLS - 1);
  localparam logic [LW-1:0]       LOAD_MID   = LW'(TAPE_CELLS / 2);
  localparam logic [LW-1:0]       LOAD_END   = LW'(TAPE_CELLS);
  localparam logic [ST_IW+3:0]    ST_LIMIT   = (ST_IW + 4)'(STATE_COUNT);
  localparam logic [SYM_IW+1:0]   SYM_LIMIT  = (SYM_IW + 2)'(SYMBOL_COUNT);

  logic [3:0] start_state;
  logic [3:0] accept_state;
  logic [1:0] blank_symbol;

  tms_pkg::func_t func;
  logic [3:0]     rule_state;
  logic [1:0]     rule_symbol;
  logic [3:0]     rule_next_state;
  logic [1:0]     rule_write_symbol;
  logic [1:0]     rule_move;
  logic [1:0]     tape_symbol;

  logic [3:0]              current_state;
  logic [HW-1:0]           head;
  logic [LW-1:0]           load_position;
  logic                    halted;
  logic [TAPE_CELLS-1:0]   cell_written;
  logic [SYMBOL_COUNT-1:0] rule_valid [STATE_COUNT];

  logic [1:0]            tape_rd;
  logic [tms_pkg::RULE_W-1:0] lane_rd [SYMBOL_COUNT];

  logic [3:0]            state_next;
  logic [HW-1:0]         head_next;
  logic [LW-1:0]         load_position_next;
  logic                  halted_next;
  logic                  tape_we;
  logic [HW-1:0]         tape_waddr;
  logic [1:0]            tape_wdata;
  logic                  mark_set;
  tms_pkg::status_t      status;
  logic [1:0]            seen;
  logic                  rule_found;
  logic                  rule_store;
  logic [tms_pkg::RULE_W-1:0] rule_sel;
  logic [ST_IW+3:0]      cur_ext;
  logic [SYM_IW+1:0]     seen_ext;
  logic [ST_IW+3:0]      wr_st_ext;
  logic [SYM_IW+1:0]     wr_sym_ext;
  logic [HW+5:0]         head_ext;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_state  <= 4'd0;
      accept_state <= 4'd15;
      blank_symbol <= 2'd0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        tms_pkg::REG_START_STATE:  start_state  <= pwdata[3:0];
        tms_pkg::REG_ACCEPT_STATE: accept_state <= pwdata[3:0];
        tms_pkg::REG_BLANK_SYMBOL: blank_symbol <= pwdata[1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      tms_pkg::REG_START_STATE:  prdata = {28'd0, start_state};
      tms_pkg::REG_ACCEPT_STATE: prdata = {28'd0, accept_state};
      tms_pkg::REG_BLANK_SYMBOL: prdata = {30'd0, blank_symbol};
      default:                   prdata = 32'd0;
    endcase
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func              <= tms_pkg::func_t'(s_tuser);
      rule_state        <= s_tdata[3:0];
      rule_symbol       <= s_tdata[5:4];
      rule_next_state   <= s_tdata[9:6];
      rule_write_symbol <= s_tdata[11:10];
      rule_move         <= s_tdata[13:12];
      tape_symbol       <= s_tdata[15:14];
    end
  end

  tms_ram #(
    .WIDTH(2),
    .DEPTH(TAPE_CELLS)
  ) u_tape (
    .clk  (clk),
    .we   (tape_we),
    .waddr(tape_waddr),
    .wdata(tape_wdata),
    .re   (cmd.accept),
    .raddr(head),
    .rdata(tape_rd)
  );

  assign cur_ext    = {{ST_IW{1'b0}}, current_state};
  assign wr_st_ext  = {{ST_IW{1'b0}}, rule_state};
  assign wr_sym_ext = {{SYM_IW{1'b0}}, rule_symbol};
  assign rule_store = cmd.execute && (func == tms_pkg::FUNC_RULE) &&
                      (wr_st_ext < ST_LIMIT) && (wr_sym_ext < SYM_LIMIT);

  for (genvar i = 0; i < SYMBOL_COUNT; i++) begin : g_lane
    tms_ram #(
      .WIDTH(tms_pkg::RULE_W),
      .DEPTH(STATE_COUNT)
    ) u_rule (
      .clk  (clk),
      .we   (rule_store && (wr_sym_ext[SYM_IW-1:0] == SYM_IW'(i))),
      .waddr(wr_st_ext[ST_IW-1:0]),
      .wdata({rule_next_state, rule_write_symbol, rule_move}),
      .re   (cmd.accept),
      .raddr(cur_ext[ST_IW-1:0]),
      .rdata(lane_rd[i])
    );
  end

  assign seen_ext   = {{SYM_IW{1'b0}}, (cell_written[head] ? tape_rd : blank_symbol)};
  assign rule_found = (cur_ext < ST_LIMIT) && (seen_ext < SYM_LIMIT) &&
                      rule_valid[cur_ext[ST_IW-1:0]][seen_ext[SYM_IW-1:0]];
  assign rule_sel   = lane_rd[seen_ext[SYM_IW-1:0]];

  always_comb begin
    state_next         = current_state;
    head_next          = head;
    load_position_next = load_position;
    halted_next        = halted;
    tape_we            = 1'b0;
    tape_waddr         = head;
    tape_wdata         = rule_sel[3:2];
    mark_set           = 1'b0;
    status             = tms_pkg::STAT_DONE;
    seen               = 2'd0;
    case (func)
      tms_pkg::FUNC_APPEND: begin
        tape_waddr = load_position[HW-1:0];
        tape_wdata = tape_symbol;
        if (load_position >= LOAD_END) begin
          status = tms_pkg::STAT_FULL;
        end else begin
          tape_we            = 1'b1;
          mark_set           = 1'b1;
          load_position_next = load_position + LW'(1);
        end
      end
      tms_pkg::FUNC_RESTART: begin
        state_next         = start_state;
        head_next          = HEAD_MID;
        load_position_next = LOAD_MID;
        halted_next        = 1'b0;
      end
      tms_pkg::FUNC_STEP: begin
        seen = seen_ext[1:0];
        if (current_state == accept_state) begin
          status = tms_pkg::STAT_ACCEPTED;
        end else if (halted) begin
          status = rule_found ? tms_pkg::STAT_OFF_TAPE : tms_pkg::STAT_NO_RULE;
        end else if (!rule_found) begin
          halted_next = 1'b1;
          status      = tms_pkg::STAT_NO_RULE;
        end else if ((rule_sel[1:0] == tms_pkg::MOVE_LEFT && head == '0) ||
                     (rule_sel[1:0] == tms_pkg::MOVE_RIGHT && head == HEAD_LAST)) begin
          halted_next = 1'b1;
          status      = tms_pkg::STAT_OFF_TAPE;
        end else begin
          tape_we    = 1'b1;
          mark_set   = 1'b1;
          state_next = rule_sel[7:4];
          if (rule_sel[1:0] == tms_pkg::MOVE_LEFT) begin
            head_next = head - HW'(1);
          end else if (rule_sel[1:0] == tms_pkg::MOVE_RIGHT) begin
            head_next = head + HW'(1);
          end
          status = (rule_sel[7:4] == accept_state) ? tms_pkg::STAT_ACCEPTED
                                                   : tms_pkg::STAT_STEPPED;
        end
      end
      default: begin
        status = tms_pkg::STAT_DONE;
      end
    endcase
    tape_we = tape_we && cmd.execute;
  end

  // Machine registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      current_state <= 4'd0;
      head          <= HEAD_MID;
      load_position <= LOAD_MID;
      halted        <= 1'b0;
      cell_written  <= '0;
      for (int s = 0; s < STATE_COUNT; s++) begin
        rule_valid[s] <= '0;
      end
    end else if (cmd.execute) begin
      current_state <= state_next;
      head          <= head_next;
      load_position <= load_position_next;
      halted        <= halted_next;
      if (func == tms_pkg::FUNC_RESTART) begin
        cell_written <= '0;
      end else if (mark_set) begin
        cell_written[tape_waddr] <= 1'b1;
      end
      if (rule_store) begin
        rule_valid[wr_st_ext[ST_IW-1:0]][wr_sym_ext[SYM_IW-1:0]] <= 1'b1;
      end
    end
  end

  // Result register.
  assign head_ext      = {6'd0, head_next};
  assign stat.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.execute) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      m_tdata <= {1'b0, seen, head_ext[5:0], state_next, status};
    end
  end

`ifndef SYNTHESIS
  a_head_on_tape: assert property (@(posedge clk) disable iff (rst)
    head <= HEAD_LAST)
    else $error("head left the tape");

  a_load_bound: assert property (@(posedge clk) disable iff (rst)
    load_position <= LOAD_END)
    else $error("load position beyond the end of the tape");

  a_halt_by_step: assert property (@(posedge clk) disable iff (rst)
    $rose(halted) |-> $past(cmd.execute && func == tms_pkg::FUNC_STEP))
    else $error("machine halted without a step");

  a_result_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.execute))
    else $error("result appeared without a request");
`endif

endmodule

FILE: sim/turing_machine_stepper_tb.sv
// ----------------------------------------------------------------------------
// turing_machine_stepper_tb: self-checking bench for the Turing machine stepper
// A shadow copy of the rule table, tape, head and halt flag predicts the
// result of every request taken on the input stream. Each result is checked
// in order against that prediction. A short directed sequence comes first.
// Randomized programs follow: rule sets, restarts, tape loads (some past the
// end of the tape), head sweeps off either edge, and step runs with stray
// requests mixed in. These run under six register settings and three
// handshake pacing modes.
// ----------------------------------------------------------------------------
localparam int TAPE_LEN = 64;

typedef struct {
  tms_pkg::status_t status;
  logic [3:0]       machine_state;
  logic [5:0]       head_position;
  logic [1:0]       symbol_seen;
} step_result_t;

class machine_mirror;
  logic [3:0]   cfg_start;
  logic [3:0]   cfg_accept;
  logic [1:0]   cfg_blank;
  bit           rule_valid [64];
  logic [3:0]   rule_next [64];
  logic [1:0]   rule_write [64];
  logic [1:0]   rule_move [64];
  logic [1:0]   tape [TAPE_LEN];
  bit           written [TAPE_LEN];
  logic [3:0]   state;
  logic [5:0]   head;
  logic [6:0]   load_pos;
  bit           halted;
  step_result_t awaited_results [$];
  int           errors;
  int           checked;
  int           status_count [8];

  function new();
    cfg_start = 4'd0;
    cfg_accept = 4'd15;
    cfg_blank = 2'd0;
    errors = 0;
    checked = 0;
    foreach (status_count[i]) status_count[i] = 0;
    foreach (rule_valid[i]) begin
      rule_valid[i] = 1'b0;
      rule_next[i] = '0;
      rule_write[i] = '0;
      rule_move[i] = '0;
    end
    restart();
  endfunction

  function void restart();
    foreach (written[i]) begin
      written[i] = 1'b0;
      tape[i] = '0;
    end
    head = 6'(TAPE_LEN / 2);
    load_pos = 7'(TAPE_LEN / 2);
    state = cfg_start;
    halted = 1'b0;
  endfunction

  function void note_request(tms_pkg::func_t f, logic [15:0] d);
    step_result_t r;
    int           idx;
    logic [5:0]   h;
    logic [1:0]   sym;
    r.status = tms_pkg::STAT_DONE;
    r.symbol_seen = 2'd0;
    case (f)
      tms_pkg::FUNC_RULE: begin
        idx = {d[3:0], d[5:4]};
        rule_valid[idx] = 1'b1;
        rule_next[idx] = d[9:6];
        rule_write[idx] = d[11:10];
        rule_move[idx] = d[13:12];
      end
      tms_pkg::FUNC_APPEND: begin
        if (load_pos >= TAPE_LEN) begin
          r.status = tms_pkg::STAT_FULL;
        end else begin
          tape[load_pos] = d[15:14];
          written[load_pos] = 1'b1;
          load_pos++;
        end
      end
      tms_pkg::FUNC_RESTART: begin
        restart();
      end
      default: begin
        h = head;
        sym = written[h] ? tape[h] : cfg_blank;
        idx = {state, sym};
        r.symbol_seen = sym;
        if (state == cfg_accept) begin
          r.status = tms_pkg::STAT_ACCEPTED;
        end else if (halted) begin
          r.status = rule_valid[idx] ? tms_pkg::STAT_OFF_TAPE : tms_pkg::STAT_NO_RULE;
        end else if (!rule_valid[idx]) begin
          halted = 1'b1;
          r.status = tms_pkg::STAT_NO_RULE;
        end else if ((rule_move[idx] == tms_pkg::MOVE_LEFT && h == 0) ||
                     (rule_move[idx] == tms_pkg::MOVE_RIGHT && h == TAPE_LEN - 1)) begin
          halted = 1'b1;
          r.status = tms_pkg::STAT_OFF_TAPE;
        end else begin
          tape[h] = rule_write[idx];
          written[h] = 1'b1;
          state = rule_next[idx];
          if (rule_move[idx] == tms_pkg::MOVE_LEFT) head = h - 6'd1;
          else if (rule_move[idx] == tms_pkg::MOVE_RIGHT) head = h + 6'd1;
          r.status = (state == cfg_accept) ? tms_pkg::STAT_ACCEPTED
                                           : tms_pkg::STAT_STEPPED;
        end
      end
    endcase
    r.machine_state = state;
    r.head_position = head;
    awaited_results.push_back(r);
  endfunction

  function void check_result(logic [15:0] data);
    step_result_t exp_r;
    logic [15:0]  want;
    if (awaited_results.size() == 0) begin
      $display("%0t: result %h arrived with no request outstanding", $time, data);
      errors++;
      return;
    end
    exp_r = awaited_results.pop_front();
    checked++;
    status_count[int'(exp_r.status)]++;
    want = {1'b0, exp_r.symbol_seen, exp_r.head_position, exp_r.machine_state,
            exp_r.status};
    if (data !== want) begin
      $display({"%0t: result mismatch: expected status %0d state %0d head %0d seen %0d,",
                " got status %0d state %0d head %0d seen %0d (word %h)"},
               $time, exp_r.status, exp_r.machine_state, exp_r.head_position,
               exp_r.symbol_seen, data[2:0], data[6:3], data[12:7], data[14:13], data);
      errors++;
    end
  endfunction
endclass

module turing_machine_stepper_tb;

  localparam logic [1:0] MOVE_STAY  = 2'd2;
  localparam logic [1:0] MOVE_SPARE = 2'd3;
  localparam int PHASES = 6;
  localparam int PHASE_REQUESTS = 305;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  machine_mirror tracker;
  int src_gap_pct = 7;
  int snk_gap_pct = 51;
  int requests_sent = 0;
  int phase_base;
  int start_set [PHASES] = '{0, 15, 5, 9, 3, 0};
  int accept_set [PHASES] = '{15, 0, 5, 12, 14, 0};
  int blank_set [PHASES] = '{0, 3, 1, 2, 1, 0};

  turing_machine_stepper u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= snk_gap_pct);
    if (!rst && m_tvalid && m_tready) tracker.check_result(m_tdata);
  end

  function automatic logic [15:0] rule_word(logic [3:0] st, logic [1:0] sym, logic [3:0] nx,
                                            logic [1:0] wr, logic [1:0] mv, logic [1:0] ts);
    return {ts, mv, wr, nx, sym, st};
  endfunction

  task automatic send_request(tms_pkg::func_t f, logic [15:0] d);
    while ($urandom_range(99) < src_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= f;
    s_tdata <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tracker.note_request(f, d);
    requests_sent++;
  endtask

  task automatic write_register(logic [1:0] idx, logic [31:0] value);
    logic [31:0] readback;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      tms_pkg::REG_START_STATE:  tracker.cfg_start = value[3:0];
      tms_pkg::REG_ACCEPT_STATE: tracker.cfg_accept = value[3:0];
      tms_pkg::REG_BLANK_SYMBOL: tracker.cfg_blank = value[1:0];
      default: ;
    endcase
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    readback = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (readback !== value) begin
      $display("%0t: register %0d read back: expected %h, got %h", $time, idx, value,
               readback);
      tracker.errors++;
    end
    @(posedge clk);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (tracker.awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_episode();
    int          nrules;
    int          nappend;
    int          nsteps;
    logic [1:0]  dir;
    logic [3:0]  st;
    logic [15:0] noise;
    if ($urandom_range(9) == 0) begin
      dir = $urandom_range(1) ? tms_pkg::MOVE_RIGHT : tms_pkg::MOVE_LEFT;
      for (int s = 0; s < 4; s++)
        send_request(tms_pkg::FUNC_RULE,
                     rule_word(tracker.cfg_start, 2'(s), tracker.cfg_start,
                               2'($urandom), dir, 2'($urandom)));
      nappend = $urandom_range(3);
      nsteps = 36;
    end else begin
      nrules = $urandom_range(1, 6);
      repeat (nrules) begin
        st = ($urandom_range(2) == 0) ? tracker.cfg_start : 4'($urandom_range(11));
        send_request(tms_pkg::FUNC_RULE,
                     rule_word(st, 2'($urandom), 4'($urandom), 2'($urandom),
                               ($urandom_range(7) == 0) ? MOVE_SPARE
                                                        : 2'($urandom_range(2)),
                               2'($urandom)));
      end
      nappend = ($urandom_range(7) == 0) ? $urandom_range(30, 36) : $urandom_range(8);
      nsteps = $urandom_range(3, 30);
    end
    send_request(tms_pkg::FUNC_RESTART, 16'($urandom));
    repeat (nappend) send_request(tms_pkg::FUNC_APPEND, 16'($urandom));
    repeat (nsteps) begin
      if ($urandom_range(19) == 0) begin
        // Stray request; its state field stays below 12, so states 12 to 14 never get a rule.
        noise = 16'($urandom);
        if (noise[3:0] > 4'd11) noise[3:0] = noise[3:0] - 4'd4;
        send_request(tms_pkg::func_t'(2'($urandom_range(3))), noise);
      end
      send_request(tms_pkg::FUNC_STEP, 16'($urandom));
    end
  endtask

  initial begin
    int n;
    tracker = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_request(tms_pkg::FUNC_STEP, 16'h0000);
    send_request(tms_pkg::FUNC_STEP, 16'hFFFF);
    send_request(tms_pkg::FUNC_RULE,
                 rule_word(4'd0, 2'd0, 4'd1, 2'd3, tms_pkg::MOVE_RIGHT, 2'd0));
    send_request(tms_pkg::FUNC_STEP, 16'h0000);
    send_request(tms_pkg::FUNC_RESTART, 16'hFFFF);
    send_request(tms_pkg::FUNC_APPEND,
                 rule_word(4'd0, 2'd0, 4'd0, 2'd0, tms_pkg::MOVE_LEFT, 2'd2));
    send_request(tms_pkg::FUNC_APPEND, 16'hFFFF);
    send_request(tms_pkg::FUNC_RULE,
                 rule_word(4'd0, 2'd2, 4'd2, 2'd1, tms_pkg::MOVE_LEFT, 2'd0));
    send_request(tms_pkg::FUNC_STEP, 16'h0000);
    send_request(tms_pkg::FUNC_RULE, rule_word(4'd2, 2'd0, 4'd3, 2'd2, MOVE_SPARE, 2'd0));
    send_request(tms_pkg::FUNC_STEP, 16'h0000);
    send_request(tms_pkg::FUNC_RULE, rule_word(4'd3, 2'd2, 4'd15, 2'd0, MOVE_STAY, 2'd0));
    send_request(tms_pkg::FUNC_STEP, 16'h0000);
    send_request(tms_pkg::FUNC_STEP, 16'h0000);
    send_request(tms_pkg::FUNC_RULE, 16'hFFFF);
    send_request(tms_pkg::FUNC_RESTART, 16'h0000);
    send_request(tms_pkg::FUNC_STEP, 16'h0000);
    send_request(tms_pkg::FUNC_STEP, 16'h0000);
    send_request(tms_pkg::FUNC_RULE, 16'h0000);
    send_request(tms_pkg::FUNC_STEP, 16'h0000);

    for (int p = 0; p < PHASES; p++) begin
      case (p / 2)
        0: begin
          src_gap_pct = 7;
          snk_gap_pct = 51;
        end
        1: begin
          src_gap_pct = 51;
          snk_gap_pct = 7;
        end
        default: begin
          src_gap_pct = 0;
          snk_gap_pct = 0;
        end
      endcase
      if (p == PHASES - 1) begin
        start_set[p] = $urandom_range(11);
        accept_set[p] = $urandom_range(15);
        blank_set[p] = $urandom_range(3);
      end
      drain_results();
      write_register(tms_pkg::REG_START_STATE, 32'(start_set[p]));
      write_register(tms_pkg::REG_ACCEPT_STATE, 32'(accept_set[p]));
      write_register(tms_pkg::REG_BLANK_SYMBOL, 32'(blank_set[p]));
      phase_base = requests_sent;
      while (requests_sent - phase_base < PHASE_REQUESTS) run_episode();
    end

    s_tvalid <= 1'b0;
    n = 0;
    while (tracker.awaited_results.size() != 0 && n < 20000) begin
      @(posedge clk);
      n++;
    end
    repeat (8) @(posedge clk);
    if (tracker.awaited_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, tracker.awaited_results.size());
      tracker.errors += tracker.awaited_results.size();
    end

    $display({"Ran %0d requests over %0d register settings and three pacing modes;",
              " %0d results checked."},
             requests_sent, PHASES, tracker.checked);
    $display({"Results seen: %0d done, %0d stepped, %0d accepted, %0d no-rule halts,",
              " %0d off-tape, %0d tape-full."},
             tracker.status_count[tms_pkg::STAT_DONE],
             tracker.status_count[tms_pkg::STAT_STEPPED],
             tracker.status_count[tms_pkg::STAT_ACCEPTED],
             tracker.status_count[tms_pkg::STAT_NO_RULE],
             tracker.status_count[tms_pkg::STAT_OFF_TAPE],
             tracker.status_count[tms_pkg::STAT_FULL]);
    if (tracker.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
